[rtl/core/bpe_pkg.sv]
// Shared constants and types for the byte pair expander.
`timescale 1ns / 1ps

package bpe_pkg;

    localparam int STACK_DEPTH  = 64;
    localparam int MAX_EXPAND   = 64;
    localparam int PAIR_ENTRIES = 128;

    localparam int PAIR_AW  = $clog2(PAIR_ENTRIES);
    localparam int STACK_AW = $clog2(STACK_DEPTH);
    localparam int SP_W     = $clog2(STACK_DEPTH + 1);
    localparam int BUF_AW   = (MAX_EXPAND > 2) ? $clog2(MAX_EXPAND) : 1;
    localparam int CNT_W    = $clog2(MAX_EXPAND + 1);

    localparam logic [15:0] OUT_LIMIT_RESET = 16'd4095;

    localparam logic FUNC_LOAD   = 1'b0;
    localparam logic FUNC_DECODE = 1'b1;

    // Handoff from the walker to the result buffer when a run is complete.
    typedef struct packed {
        logic             go;
        logic [CNT_W-1:0] count;
        logic             trunc;
        logic             limit;
    } run_t;

endpackage

[rtl/core/byte_pair_expander_unit.sv]
// Byte pair expander top level: pair table, expansion stack walker and budget.
//
// Usage:
//   Slave side (s_*) takes one transaction per item. s_tuser selects the function:
//   load (write one pair table entry) or decode (expand one code byte).
//   A code byte below 128 is a literal; 128 and above names pair entry (code-128),
//   expanded depth first through a 64-entry stack held in block RAM.
//   Master side (m_*) carries one transaction per emitted byte; m_tlast closes the
//   run of one code byte, m_tuser flags truncation and budget exhaustion for the run.
//   cfg_we/cfg_wdata write out_limit, the per-block byte budget (reset 4095);
//   write it only while the block is idle. block_start clears the byte count.
// Flow:
//   A load writes its pair table entry on acceptance. A decode walks the pair
//   table and stack node by node (a RAM read step, an evaluate step), then plays
//   the run out of a result buffer, each byte read from it and then moved into the
//   output register; a literal also takes this path. All RAM reads are registered.
//   s_tready drops from acceptance of a decode until its walk ends and its last
//   byte has moved into the output register; a stalled receiver holds that byte in
//   the output register while the next item is taken.
// Reset: synchronous, active low; clears control state and the byte count.
//   Pair table contents are undefined until loaded.
`timescale 1ns / 1ps

module byte_pair_expander_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [6:0] pair_index, [14:7] pair_first,
                                   // [22:15] pair_second, [30:23] code_byte,
                                   // [31] block_start
    input  logic        s_tuser,   // func
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [6:0] out_byte, [7] zero
    output logic        m_tlast,   // last_of_run
    output logic [1:0]  m_tuser    // [0] truncated, [1] limit_reached
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_WALK  = 2'd1;
    localparam logic [1:0] S_PAIR  = 2'd2;
    localparam logic [1:0] S_STACK = 2'd3;

    logic [1:0]                    state_reg, state_next;
    logic [7:0]                    cur_reg, cur_next;
    logic [bpe_pkg::SP_W-1:0]      sp_reg, sp_next;
    logic [bpe_pkg::CNT_W-1:0]     n_reg, n_next;
    logic [15:0]                   emitted_reg, emitted_next;
    logic [15:0]                   out_limit_reg;

    logic [15:0] pair_mem [bpe_pkg::PAIR_ENTRIES];
    logic [7:0]  stack_mem [bpe_pkg::STACK_DEPTH];
    logic [15:0] pair_rdata;
    logic [7:0]  stack_rdata;

    logic                          accept;
    logic                          pair_we;
    logic                          stack_we;
    logic [bpe_pkg::STACK_AW-1:0]  stack_waddr;
    logic [bpe_pkg::STACK_AW-1:0]  stack_raddr;
    logic [bpe_pkg::SP_W-1:0]      sp_dec;
    logic                          buf_we;
    logic                          drain_busy;
    bpe_pkg::run_t                 run;

    logic       in_func;
    logic [6:0] in_index;
    logic [7:0] in_first;
    logic [7:0] in_second;
    logic [7:0] in_code;
    logic       in_start;

    assign in_index  = s_tdata[6:0];
    assign in_first  = s_tdata[14:7];
    assign in_second = s_tdata[22:15];
    assign in_code   = s_tdata[30:23];
    assign in_start  = s_tdata[31];
    assign in_func   = s_tuser;

    assign s_tready = (state_reg == S_IDLE) && !drain_busy;
    assign accept   = s_tvalid && s_tready;
    assign pair_we  = accept && (in_func == bpe_pkg::FUNC_LOAD);

    assign sp_dec      = sp_reg - bpe_pkg::SP_W'(1);
    assign stack_raddr = sp_dec[bpe_pkg::STACK_AW-1:0];
    assign stack_waddr = sp_reg[bpe_pkg::STACK_AW-1:0];

    // Pair table and stack, registered reads
    always_ff @(posedge aclk) begin
        if (pair_we) begin
            pair_mem[in_index] <= {in_second, in_first};
        end
        pair_rdata <= pair_mem[cur_reg[bpe_pkg::PAIR_AW-1:0]];
        if (stack_we) begin
            stack_mem[stack_waddr] <= pair_rdata[15:8];
        end
        stack_rdata <= stack_mem[stack_raddr];
    end

    always_comb begin
        state_next   = state_reg;
        cur_next     = cur_reg;
        sp_next      = sp_reg;
        n_next       = n_reg;
        emitted_next = emitted_reg;
        stack_we     = 1'b0;
        buf_we       = 1'b0;
        run.go       = 1'b0;
        run.count    = n_reg;
        run.trunc    = 1'b0;
        run.limit    = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                if (accept && (in_func == bpe_pkg::FUNC_DECODE)) begin
                    cur_next   = in_code;
                    sp_next    = '0;
                    n_next     = '0;
                    state_next = S_WALK;
                    if (in_start) begin
                        emitted_next = '0;
                    end
                end
            end
            S_WALK: begin
                if (cur_reg[7]) begin
                    if (sp_reg == bpe_pkg::SP_W'(bpe_pkg::STACK_DEPTH)) begin
                        run.go     = (n_reg != '0);
                        run.trunc  = 1'b1;
                        state_next = S_IDLE;
                    end else begin
                        state_next = S_PAIR;
                    end
                end else if (emitted_reg >= out_limit_reg) begin
                    // budget check comes before the expansion cap
                    run.go     = (n_reg != '0);
                    run.limit  = 1'b1;
                    state_next = S_IDLE;
                end else if (n_reg == bpe_pkg::CNT_W'(bpe_pkg::MAX_EXPAND)) begin
                    run.go     = 1'b1;
                    run.trunc  = 1'b1;
                    state_next = S_IDLE;
                end else begin
                    buf_we       = 1'b1;
                    n_next       = n_reg + bpe_pkg::CNT_W'(1);
                    emitted_next = emitted_reg + 16'd1;
                    if (sp_reg == '0) begin
                        run.go     = 1'b1;
                        run.count  = n_next;
                        state_next = S_IDLE;
                    end else begin
                        sp_next    = sp_dec;
                        state_next = S_STACK;
                    end
                end
            end
            S_PAIR: begin
                stack_we   = 1'b1;
                sp_next    = sp_reg + bpe_pkg::SP_W'(1);
                cur_next   = pair_rdata[7:0];
                state_next = S_WALK;
            end
            S_STACK: begin
                cur_next   = stack_rdata;
                state_next = S_WALK;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            sp_reg        <= '0;
            n_reg         <= '0;
            emitted_reg   <= '0;
            out_limit_reg <= bpe_pkg::OUT_LIMIT_RESET;
        end else begin
            state_reg   <= state_next;
            sp_reg      <= sp_next;
            n_reg       <= n_next;
            emitted_reg <= emitted_next;
            if (cfg_we) begin
                out_limit_reg <= cfg_wdata;
            end
        end
        cur_reg <= cur_next;
    end

    bpe_run_buf u_run_buf (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (buf_we),
        .wr_addr  (n_reg[bpe_pkg::BUF_AW-1:0]),
        .wr_data  (cur_reg[6:0]),
        .run      (run),
        .busy     (drain_busy),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    a_sp_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        sp_reg <= bpe_pkg::SP_W'(bpe_pkg::STACK_DEPTH))
        else $error("expansion stack pointer overflow");

    a_n_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        n_reg <= bpe_pkg::CNT_W'(bpe_pkg::MAX_EXPAND))
        else $error("run length past expansion cap");

    a_pair_after_walk: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_PAIR || state_reg == S_STACK) |-> ($past(state_reg) == S_WALK))
        else $error("RAM wait state entered without an issuing walk step");

    a_go_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        run.go |-> (run.count != '0))
        else $error("empty run handed to result buffer");

endmodule

[rtl/core/bpe_run_buf.sv]
// Result buffer: holds one run of expanded bytes and plays it out on the master side.
`timescale 1ns / 1ps

module bpe_run_buf (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       wr_en,
    input  logic [bpe_pkg::BUF_AW-1:0] wr_addr,
    input  logic [6:0]                 wr_data,
    input  bpe_pkg::run_t              run,
    output logic                       busy,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [7:0]                 m_tdata,   // [6:0] out_byte, [7] zero
    output logic                       m_tlast,   // last_of_run
    output logic [1:0]                 m_tuser    // [0] truncated, [1] limit_reached
);

    logic [6:0] buf_mem [bpe_pkg::MAX_EXPAND];
    logic [6:0] rdata_reg;

    logic                        busy_reg, busy_next;
    logic                        phase_reg, phase_next;
    logic [bpe_pkg::CNT_W-1:0]   rd_reg, rd_next;
    logic [bpe_pkg::CNT_W-1:0]   count_reg, count_next;
    logic                        trunc_reg, trunc_next;
    logic                        limit_reg, limit_next;
    logic                        valid_reg, valid_next;
    logic [6:0]                  byte_reg, byte_next;
    logic                        last_reg, last_next;
    logic [1:0]                  flags_reg, flags_next;
    logic                        put;
    logic [bpe_pkg::CNT_W-1:0]   rd_inc;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            buf_mem[wr_addr] <= wr_data;
        end
        rdata_reg <= buf_mem[rd_reg[bpe_pkg::BUF_AW-1:0]];
    end

    assign rd_inc = rd_reg + bpe_pkg::CNT_W'(1);
    // phase: data for rd_reg has settled in rdata_reg
    assign put    = busy_reg && phase_reg && (!valid_reg || m_tready);

    always_comb begin
        busy_next  = busy_reg;
        phase_next = phase_reg;
        rd_next    = rd_reg;
        count_next = count_reg;
        trunc_next = trunc_reg;
        limit_next = limit_reg;
        byte_next  = byte_reg;
        last_next  = last_reg;
        flags_next = flags_reg;
        valid_next = (valid_reg && !m_tready);
        if (run.go) begin
            busy_next  = 1'b1;
            phase_next = 1'b0;
            rd_next    = '0;
            count_next = run.count;
            trunc_next = run.trunc;
            limit_next = run.limit;
        end else if (put) begin
            valid_next = 1'b1;
            byte_next  = rdata_reg;
            last_next  = (rd_inc == count_reg);
            flags_next = {limit_reg, trunc_reg};
            rd_next    = rd_inc;
            phase_next = 1'b0;
            if (rd_inc == count_reg) begin
                busy_next = 1'b0;
            end
        end else if (busy_reg && !phase_reg) begin
            phase_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            phase_reg <= 1'b0;
            valid_reg <= 1'b0;
            rd_reg    <= '0;
        end else begin
            busy_reg  <= busy_next;
            phase_reg <= phase_next;
            valid_reg <= valid_next;
            rd_reg    <= rd_next;
        end
        count_reg <= count_next;
        trunc_reg <= trunc_next;
        limit_reg <= limit_next;
        byte_reg  <= byte_next;
        last_reg  <= last_next;
        flags_reg <= flags_next;
    end

    assign busy     = busy_reg;
    assign m_tvalid = valid_reg;
    assign m_tdata  = {1'b0, byte_reg};
    assign m_tlast  = last_reg;
    assign m_tuser  = flags_reg;

    a_no_go_while_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        run.go |-> !busy_reg)
        else $error("run handed over while previous run still draining");

    a_rd_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> (rd_reg < count_reg))
        else $error("read pointer ran past run length");

    a_last_ends_run: assert property (@(posedge aclk) disable iff (!aresetn)
        (put && (rd_inc == count_reg)) |=> (!busy_reg && m_tlast && m_tvalid))
        else $error("final byte did not close the run");

endmodule
